// ----- rtl/core/mle_pkg.sv -----
package mle_pkg;

  // Default sizes
  localparam int unsigned ID_BITS_DEF    = 16;
  localparam int unsigned PORT_COUNT_DEF = 4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_CONN = 1'b1;

  // Received item commands
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ID    = 2'd1,
    CMD_ACK   = 2'd2
  } cmd_e;

  // Sent message kinds
  typedef enum logic [1:0] {
    KIND_ID     = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_MASTER = 2'd2
  } kind_e;

endpackage

// ----- rtl/core/min_id_leader_election_node.sv -----
// One node of a mesh that elects the smallest identifier by flooding with echo
// acknowledgements.
// Input channel (in_valid_i / in_stall_o): one received item per transaction,
// command_i (start, id message, ack message), port_i and value_i.
// Output channel (out_valid_o / out_stall_i): one message per transaction,
// send_port_o, send_kind_o, send_value_o, is_master_o and last_o, which marks
// the final message caused by one input item. Items that cause no message
// produce nothing on the output.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (node id, connected-port mask); write only while the block is idle.
// The messages of an accepted item pass through the group register and then
// the single-message output register.
// Throughput: the state update is one pass of logic, so an item is taken every
// cycle while no message group is waiting to drain; an item that causes
// messages keeps the input stalled while the output register drains its
// message group one message at a time. The next item is taken in the cycle the
// last message of the previous group moves into the output register.
// Reset clears the election state, the configuration and both buffers.
// A stalled output holds its message, and the group behind it waits.
module min_id_leader_election_node #(
  parameter int unsigned ID_BITS    = mle_pkg::ID_BITS_DEF,
  parameter int unsigned PORT_COUNT = mle_pkg::PORT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [mle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [((ID_BITS > PORT_COUNT) ? ID_BITS : PORT_COUNT)-1:0] cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [$clog2(PORT_COUNT)-1:0] port_i,
  input  logic [ID_BITS-1:0]            value_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [$clog2(PORT_COUNT)-1:0] send_port_o,
  output logic [1:0]                    send_kind_o,
  output logic [ID_BITS-1:0]            send_value_o,
  output logic                          is_master_o,
  output logic                          last_o
);

  localparam int unsigned PortW = $clog2(PORT_COUNT);
  localparam int unsigned PendW = $clog2(PORT_COUNT + 1);

  // Configuration registers
  logic [ID_BITS-1:0]    node_id_q;
  logic [PORT_COUNT-1:0] port_conn_q;

  // Election state
  logic [ID_BITS-1:0] smallest_q, smallest_d;
  logic [PortW-1:0]   parent_q, parent_d;
  logic               parent_vld_q, parent_vld_d;
  logic [PendW-1:0]   pend_q, pend_d;
  logic               pend_uf_q, pend_uf_d;
  logic               master_q, master_d;
  logic               done_q, done_d;

  // Message group waiting to drain
  logic [PORT_COUNT-1:0] grp_mask_q, grp_mask_d, new_mask;
  mle_pkg::kind_e        grp_kind_q, new_kind;
  logic [ID_BITS-1:0]    grp_value_q;
  logic                  grp_master_q;

  // Output register
  logic               out_valid_q;
  logic [PortW-1:0]   out_port_q;
  mle_pkg::kind_e     out_kind_q;
  logic [ID_BITS-1:0] out_value_q;
  logic               out_master_q;
  logic               out_last_q;

  logic                  in_acc;
  logic                  load;
  logic [PortW-1:0]      sel_port;
  logic [PORT_COUNT-1:0] rest_mask;
  logic                  sel_last;
  logic [PORT_COUNT-1:0] arr_onehot;
  logic [PORT_COUNT-1:0] parent_onehot;
  logic [PORT_COUNT-1:0] fwd_mask;
  logic [PendW-1:0]      conn_cnt;
  logic [PendW-1:0]      fwd_cnt;

  // Pick the lowest pending port of the group
  always_comb begin
    sel_port = '0;
    for (int i = PORT_COUNT - 1; i >= 0; i--) begin
      if (grp_mask_q[i]) begin
        sel_port = PortW'(i);
      end
    end
  end

  assign rest_mask  = grp_mask_q & ~(PORT_COUNT'(1) << sel_port);
  assign sel_last   = (rest_mask == '0);
  assign load       = (grp_mask_q != '0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (grp_mask_q != '0) && !(load && sel_last);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Port masks and their counts
  assign arr_onehot    = PORT_COUNT'(1) << port_i;
  assign parent_onehot = PORT_COUNT'(1) << parent_q;
  assign fwd_mask      = port_conn_q & ~arr_onehot;

  always_comb begin
    conn_cnt = '0;
    fwd_cnt  = '0;
    for (int i = 0; i < PORT_COUNT; i++) begin
      conn_cnt = conn_cnt + PendW'(port_conn_q[i]);
      fwd_cnt  = fwd_cnt + PendW'(fwd_mask[i]);
    end
  end

  // Election step for one accepted item
  always_comb begin
    smallest_d   = smallest_q;
    parent_d     = parent_q;
    parent_vld_d = parent_vld_q;
    pend_d       = pend_q;
    pend_uf_d    = pend_uf_q;
    master_d     = master_q;
    done_d       = done_q;
    new_mask     = '0;
    new_kind     = mle_pkg::KIND_ID;
    case (command_i)
      mle_pkg::CMD_START: begin
        smallest_d   = node_id_q;
        parent_d     = '0;
        parent_vld_d = 1'b0;
        master_d     = 1'b0;
        done_d       = 1'b0;
        pend_uf_d    = 1'b0;
        pend_d       = conn_cnt;
        new_mask     = port_conn_q;
        new_kind     = mle_pkg::KIND_ID;
      end
      mle_pkg::CMD_ID: begin
        if (!done_q) begin
          if (value_i == smallest_q) begin
            new_mask = arr_onehot;
            new_kind = mle_pkg::KIND_ACK;
          end else if (value_i < smallest_q) begin
            // adopt the smaller id and forward it, or echo when no other port
            smallest_d   = value_i;
            parent_d     = port_i;
            parent_vld_d = 1'b1;
            pend_uf_d    = 1'b0;
            pend_d       = fwd_cnt;
            if (fwd_mask == '0) begin
              new_mask = arr_onehot;
              new_kind = mle_pkg::KIND_ACK;
            end else begin
              new_mask = fwd_mask;
              new_kind = mle_pkg::KIND_ID;
            end
          end
        end
      end
      mle_pkg::CMD_ACK: begin
        if (!done_q && value_i == smallest_q && !pend_uf_q) begin
          if (pend_q == '0) begin
            pend_uf_d = 1'b1;
          end else begin
            pend_d = pend_q - PendW'(1);
            if (pend_q == PendW'(1)) begin
              if (smallest_q == node_id_q) begin
                master_d = 1'b1;
                done_d   = 1'b1;
                new_mask = port_conn_q;
                new_kind = mle_pkg::KIND_MASTER;
              end else if (parent_vld_q) begin
                new_mask = parent_onehot;
                new_kind = mle_pkg::KIND_ACK;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Group mask: reload on accept, else shrink as messages leave
  always_comb begin
    grp_mask_d = grp_mask_q;
    if (in_acc) begin
      grp_mask_d = new_mask;
    end else if (load) begin
      grp_mask_d = rest_mask;
    end
  end

  // Hold configuration, state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= '0;
      port_conn_q  <= '0;
      smallest_q   <= '0;
      parent_q     <= '0;
      parent_vld_q <= 1'b0;
      pend_q       <= '0;
      pend_uf_q    <= 1'b0;
      master_q     <= 1'b0;
      done_q       <= 1'b0;
      grp_mask_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mle_pkg::CFG_NODE_ID:   node_id_q   <= cfg_wdata_i[ID_BITS-1:0];
          mle_pkg::CFG_PORT_CONN: port_conn_q <= cfg_wdata_i[PORT_COUNT-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        smallest_q   <= smallest_d;
        parent_q     <= parent_d;
        parent_vld_q <= parent_vld_d;
        pend_q       <= pend_d;
        pend_uf_q    <= pend_uf_d;
        master_q     <= master_d;
        done_q       <= done_d;
      end
      grp_mask_q <= grp_mask_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Group and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      grp_kind_q   <= new_kind;
      grp_value_q  <= smallest_d;
      grp_master_q <= master_d;
    end
    if (load) begin
      out_port_q   <= sel_port;
      out_kind_q   <= grp_kind_q;
      out_value_q  <= grp_value_q;
      out_master_q <= grp_master_q;
      out_last_q   <= sel_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign send_port_o  = out_port_q;
  assign send_kind_o  = out_kind_q;
  assign send_value_o = out_value_q;
  assign is_master_o  = out_master_q;
  assign last_o       = out_last_q;

  // A declared master has finished its election
  assert property (@(posedge clk_i) disable iff (!rst_ni) master_q |-> done_q)
    else $error("master flag set without election done");

  // A master declaration group is only built once the flag is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((grp_mask_q != '0) && (grp_kind_q == mle_pkg::KIND_MASTER)) |-> grp_master_q)
    else $error("master declaration queued without master flag");

  // Pending answers never exceed the number of ports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(PORT_COUNT))
    else $error("pending answer count out of range");

  // An accepted item that causes messages always leaves a message group to drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && new_mask != '0) |=> (grp_mask_q != '0))
    else $error("accepted item lost its message group");

endmodule

// ----- sim/min_id_leader_election_node_checker.sv -----
module min_id_leader_election_node_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          cfg_we_i,
  input  logic [mle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    command_i,
  input  logic [1:0]                    port_i,
  input  logic [15:0]                   value_i,
  // output channel
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [1:0]                    send_port_i,
  input  logic [1:0]                    send_kind_i,
  input  logic [15:0]                   send_value_i,
  input  logic                          is_master_i,
  input  logic                          last_i,
  // status toward the testbench top
  output int                            mismatch_cnt_o,
  output int                            msgs_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]     port;
    mle_pkg::kind_e kind;
    logic [15:0]    value;
    logic           master;
    logic           last;
  } elect_msg_t;

  // Predicted node state and configuration copy
  logic [15:0] own_id_q;
  logic [3:0]  link_mask_q;
  logic [15:0] min_id_q;
  logic [1:0]  parent_q;
  logic        parent_ok_q;
  logic [2:0]  answers_q;
  logic        underflow_q;
  logic        master_q;
  logic        done_q;

  // Messages of the item being predicted, and all messages still owed
  elect_msg_t group_q[$];
  elect_msg_t msg_due_q[$];

  // Append one message carrying the current minimum
  function automatic void queue_msg(input logic [1:0] p, input mle_pkg::kind_e k);
    elect_msg_t m;
    m.port   = p;
    m.kind   = k;
    m.value  = min_id_q;
    m.master = 1'b0;
    m.last   = 1'b0;
    group_q.push_back(m);
  endfunction

  // Send the minimum on every connected port, optionally skipping one
  function automatic int flood_links(input logic skip_en, input logic [1:0] skip,
                                     input mle_pkg::kind_e k);
    int cnt;
    int p;
    cnt = 0;
    for (p = 0; p < 4; p++) begin
      if (link_mask_q[p] && !(skip_en && p[1:0] == skip)) begin
        queue_msg(p[1:0], k);
        cnt++;
      end
    end
    return cnt;
  endfunction

  // Advance the election by one received item and queue its messages
  task automatic elect_step(input logic [1:0] cmd, input logic [1:0] port,
                            input logic [15:0] val);
    int sent;
    int i;
    elect_msg_t m;
    group_q.delete();
    case (cmd)
      mle_pkg::CMD_START: begin
        min_id_q    = own_id_q;
        parent_q    = 2'd0;
        parent_ok_q = 1'b0;
        master_q    = 1'b0;
        done_q      = 1'b0;
        underflow_q = 1'b0;
        sent        = flood_links(1'b0, 2'd0, mle_pkg::KIND_ID);
        answers_q   = sent[2:0];
      end
      mle_pkg::CMD_ID: begin
        if (!done_q) begin
          if (val == min_id_q) begin
            queue_msg(port, mle_pkg::KIND_ACK);
          end else if (val < min_id_q) begin
            min_id_q    = val;
            parent_q    = port;
            parent_ok_q = 1'b1;
            underflow_q = 1'b0;
            sent        = flood_links(1'b1, port, mle_pkg::KIND_ID);
            answers_q   = sent[2:0];
            if (sent == 0) queue_msg(port, mle_pkg::KIND_ACK);
          end
        end
      end
      mle_pkg::CMD_ACK: begin
        if (!done_q && val == min_id_q && !underflow_q) begin
          if (answers_q == 3'd0) begin
            underflow_q = 1'b1;
          end else begin
            answers_q = answers_q - 3'd1;
            if (answers_q == 3'd0) begin
              if (min_id_q == own_id_q) begin
                master_q = 1'b1;
                done_q   = 1'b1;
                sent     = flood_links(1'b0, 2'd0, mle_pkg::KIND_MASTER);
              end else if (parent_ok_q) begin
                queue_msg(parent_q, mle_pkg::KIND_ACK);
              end
            end
          end
        end
      end
      default: ;
    endcase
    // Stamp the master flag and mark the final message of the group
    for (i = 0; i < group_q.size(); i++) begin
      m        = group_q[i];
      m.master = master_q;
      m.last   = (i == group_q.size() - 1);
      msg_due_q.push_back(m);
    end
  endtask

  // Track writes, predict on input transactions, compare output transactions
  always @(posedge clk_i or negedge rst_ni) begin : watch_b
    elect_msg_t want;
    if (!rst_ni) begin
      own_id_q       = 16'd0;
      link_mask_q    = 4'd0;
      min_id_q       = 16'd0;
      parent_q       = 2'd0;
      parent_ok_q    = 1'b0;
      answers_q      = 3'd0;
      underflow_q    = 1'b0;
      master_q       = 1'b0;
      done_q         = 1'b0;
      mismatch_cnt_o = 0;
      msg_due_q.delete();
      msgs_due_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mle_pkg::CFG_NODE_ID:   own_id_q    = cfg_wdata_i;
          mle_pkg::CFG_PORT_CONN: link_mask_q = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) elect_step(command_i, port_i, value_i);
      if (out_valid_i && !out_stall_i) begin
        if (msg_due_q.size() == 0) begin
          $error("unexpected message: send_port %0d send_kind %0d send_value %h",
                 send_port_i, send_kind_i, send_value_i);
          mismatch_cnt_o++;
        end else begin
          want = msg_due_q.pop_front();
          if (send_port_i !== want.port) begin
            $error("send_port: expected %0d, got %0d", want.port, send_port_i);
            mismatch_cnt_o++;
          end
          if (send_kind_i !== want.kind) begin
            $error("send_kind: expected %0d, got %0d", want.kind, send_kind_i);
            mismatch_cnt_o++;
          end
          if (send_value_i !== want.value) begin
            $error("send_value: expected %h, got %h", want.value, send_value_i);
            mismatch_cnt_o++;
          end
          if (is_master_i !== want.master) begin
            $error("is_master: expected %0d, got %0d", want.master, is_master_i);
            mismatch_cnt_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_i);
            mismatch_cnt_o++;
          end
        end
      end
      msgs_due_o <= msg_due_q.size();
    end
  end

endmodule

// ----- sim/min_id_leader_election_node_tb.sv -----
module min_id_leader_election_node_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_RSVD       = 2'd3;
  localparam int         HOLD_CYCLES    = 200;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         ITEM_TARGET    = 420;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [mle_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [15:0]                   cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    command;
  logic [1:0]                    port;
  logic [15:0]                   value;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    send_port;
  logic [1:0]                    send_kind;
  logic [15:0]                   send_value;
  logic                          is_master;
  logic                          last;

  int mismatch_cnt;
  int msgs_due;
  int items_sent = 0;
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;

  min_id_leader_election_node dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .port_i       (port),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .send_port_o  (send_port),
    .send_kind_o  (send_kind),
    .send_value_o (send_value),
    .is_master_o  (is_master),
    .last_o       (last)
  );

  min_id_leader_election_node_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .port_i         (port),
    .value_i        (value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .send_port_i    (send_port),
    .send_kind_i    (send_kind),
    .send_value_i   (send_value),
    .is_master_i    (is_master),
    .last_i         (last),
    .mismatch_cnt_o (mismatch_cnt),
    .msgs_due_o     (msgs_due)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin : watchdog_b
    int idle_n;
    idle_n = 0;
    while (idle_n < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_n = 0;
      else idle_n++;
    end
    $display("[min_id_leader_election_node] ERROR");
    $finish;
  end

  task automatic write_reg(input logic [mle_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer one item, hold it until taken, then maybe idle
  task automatic offer_item(input logic [1:0] cmd, input logic [1:0] p,
                            input logic [15:0] val);
    in_valid <= 1'b1;
    command  <= cmd;
    port     <= p;
    value    <= val;
    do @(posedge clk); while (in_stall);
    if (cmd != CMD_RSVD) items_sent++;
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every owed message has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (msgs_due != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stim_b
    int          k;
    int          scen;
    int          n_ops;
    int          r;
    logic [15:0] own;
    logic [15:0] cur_min;
    logic [15:0] v;
    logic [3:0]  mask;
    bit          may_adopt;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= mle_pkg::CFG_NODE_ID;
    cfg_wdata <= 16'd0;
    in_valid  <= 1'b0;
    command   <= mle_pkg::CMD_START;
    port      <= 2'd0;
    value     <= 16'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Isolated node: no neighbours, equal id, larger id, unknown command, underflow
    write_reg(mle_pkg::CFG_NODE_ID, 16'h8000);
    write_reg(mle_pkg::CFG_PORT_CONN, 16'h0000);
    offer_item(mle_pkg::CMD_START, 2'd1, 16'h0000);
    offer_item(mle_pkg::CMD_ID, 2'd2, 16'h8000);
    offer_item(mle_pkg::CMD_ID, 2'd1, 16'hFFFF);
    offer_item(CMD_RSVD, 2'd3, 16'hFFFF);
    offer_item(mle_pkg::CMD_ACK, 2'd0, 16'h8000);
    offer_item(mle_pkg::CMD_ACK, 2'd1, 16'h8000);
    offer_item(mle_pkg::CMD_ID, 2'd3, 16'h0000);
    wait_drained();

    // Fully connected: master declaration, items after election, restart, echo to parent
    write_reg(mle_pkg::CFG_NODE_ID, 16'hFFFF);
    write_reg(mle_pkg::CFG_PORT_CONN, 16'hFFFF);
    offer_item(mle_pkg::CMD_START, 2'd0, 16'h0000);
    for (k = 0; k < 4; k++) offer_item(mle_pkg::CMD_ACK, 2'(3 - k), 16'hFFFF);
    offer_item(mle_pkg::CMD_ID, 2'd0, 16'h0001);
    offer_item(mle_pkg::CMD_ACK, 2'd2, 16'hFFFF);
    offer_item(mle_pkg::CMD_START, 2'd3, 16'hFFFF);
    offer_item(mle_pkg::CMD_ID, 2'd1, 16'h1234);
    for (k = 0; k < 3; k++) offer_item(mle_pkg::CMD_ACK, 2'(k), 16'h1234);
    wait_drained();

    // Own id rewritten after start: the count runs out with no parent
    write_reg(mle_pkg::CFG_NODE_ID, 16'd5);
    write_reg(mle_pkg::CFG_PORT_CONN, 16'h0005);
    offer_item(mle_pkg::CMD_START, 2'd0, 16'd0);
    wait_drained();
    write_reg(mle_pkg::CFG_NODE_ID, 16'd9);
    offer_item(mle_pkg::CMD_ACK, 2'd0, 16'd5);
    offer_item(mle_pkg::CMD_ACK, 2'd2, 16'd5);
    wait_drained();

    // Random elections, each under a fresh configuration
    scen = 0;
    while (items_sent < ITEM_TARGET) begin
      scen++;
      quiet = (scen >= 8 && scen < 12);
      case ($urandom_range(9))
        0:       own = 16'h0000;
        1:       own = 16'hFFFF;
        default: own = 16'($urandom);
      endcase
      case ($urandom_range(7))
        0:       mask = 4'h0;
        1, 2:    mask = 4'hF;
        default: mask = 4'($urandom);
      endcase
      // all ports connected while the receiver holds off, so the block fills up
      if (scen == 3) mask = 4'hF;
      write_reg(mle_pkg::CFG_NODE_ID, own);
      write_reg(mle_pkg::CFG_PORT_CONN, {12'($urandom), mask});
      may_adopt = $urandom_range(1);
      cur_min   = own;
      if (scen == 3) hold_req = 1'b1;
      offer_item(mle_pkg::CMD_START, 2'($urandom), 16'($urandom));
      n_ops = $urandom_range(16, 6);
      for (k = 0; k < n_ops; k++) begin
        if (scen == 5 && k == n_ops / 2) wait_drained();
        r = $urandom_range(99);
        if (r < 45) begin
          offer_item(mle_pkg::CMD_ACK, 2'($urandom), cur_min);
        end else if (r < 65) begin
          offer_item(mle_pkg::CMD_ID, 2'($urandom), cur_min);
        end else if (r < 75 && may_adopt && cur_min != 16'd0) begin
          v       = 16'($urandom_range(int'(cur_min) - 1, 0));
          cur_min = v;
          offer_item(mle_pkg::CMD_ID, 2'($urandom), v);
        end else if (r < 85) begin
          v = 16'($urandom);
          if (v < cur_min) cur_min = v;
          offer_item(mle_pkg::CMD_ID, 2'($urandom), v);
        end else if (r < 92) begin
          offer_item(mle_pkg::CMD_ACK, 2'($urandom), 16'($urandom));
        end else if (r < 96) begin
          cur_min = own;
          offer_item(mle_pkg::CMD_START, 2'($urandom), 16'($urandom));
        end else begin
          offer_item(CMD_RSVD, 2'($urandom), 16'($urandom));
        end
      end
      wait_drained();
    end

    quiet = 1'b0;
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && msgs_due == 0) begin
      $display("[min_id_leader_election_node] OK");
    end else begin
      $display("[min_id_leader_election_node] ERROR");
    end
    $finish;
  end

endmodule
